// File: rtl/ifs_chaos_point_generator_unit_assert.svh
`ifndef IFS_CHAOS_POINT_GENERATOR_UNIT_ASSERT_SVH
`define IFS_CHAOS_POINT_GENERATOR_UNIT_ASSERT_SVH
// Same-cycle implication, checked while out of reset.
`define IFSCPG_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked while out of reset.
`define IFSCPG_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/ifscpg_pkg.sv
package ifscpg_pkg;

  localparam int MAX_T       = 8;
  localparam int ITERATIONS  = 10;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int STEP_W      = 4;
  localparam int ELEM_W      = 5;
  localparam int ELEMENTS    = 20;
  localparam int ROWS_PER_T  = 5;
  localparam int MEM_ROWS    = MAX_T * ROWS_PER_T;
  localparam int ADDR_W      = $clog2(MEM_ROWS);
  localparam int CHOICE_W    = 30;
  localparam int DIV_W       = 40;
  localparam int DIV_CHUNK   = 8;
  localparam int DIV_CYC     = DIV_W / DIV_CHUNK;
  localparam int DIV_CNT_W   = $clog2(DIV_CYC + 1);

  localparam logic signed [31:0] ONE_FIX     = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] START_COLOR = 32'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] START_SIZE  = 32'sd10 <<< FRAC_BITS;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_GEN  = 1'b1;

  localparam logic [2:0] REG_COUNT_ADDR = 3'd0;

  typedef struct packed {
    logic                  func;
    logic [IDX_W-1:0]      entry;
    logic [ELEM_W-1:0]     element;
    logic signed [31:0]    word;
    logic signed [31:0]    origin_x;
    logic signed [31:0]    origin_y;
    logic signed [31:0]    origin_z;
    logic [CHOICE_W-1:0]   choices;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] color_r;
    logic signed [31:0] color_g;
    logic signed [31:0] color_b;
    logic signed [31:0] dot_size;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF)
      return 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000)
      return 32'sh8000_0000;
    else
      return v[31:0];
  endfunction

endpackage

// File: rtl/ifscpg_avgdiv.sv
module ifscpg_avgdiv
  import ifscpg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic signed [31:0]  cur,
  input  logic signed [31:0]  add,
  input  logic [STEP_W-1:0]   step,
  output logic signed [31:0]  result
);

  localparam int D_W = STEP_W + 2;

  logic [D_W-1:0]          n1, d;
  logic signed [37:0]      scaled;
  logic [DIV_W-1:0]        mval, mag;
  logic                    neg;
  logic [DIV_W-1:0]        acc_r, acc_nxt;
  logic [D_W-1:0]          rem_r, rem_nxt, d_r;
  logic                    neg_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [D_W:0]            trial;
  logic signed [DIV_W:0]   qs;

  // rounded average: floor((2*num + d) / (2*d)) == floor((num + d/2) / d)
  assign n1     = D_W'(step) + D_W'(1);
  assign d      = D_W'(step) + D_W'(2);
  assign scaled = 38'(cur * $signed({1'b0, n1}));
  assign mval   = {{(DIV_W-38){scaled[37]}}, scaled} + {{(DIV_W-32){add[31]}}, add}
                + DIV_W'(d >> 1);
  assign neg    = mval[DIV_W-1];
  // floor of a negative quotient: -ceil(|m| / d)
  assign mag    = neg ? (DIV_W'(0) - mval + DIV_W'(d) - DIV_W'(1)) : mval;

  always_comb begin
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    trial   = '0;
    for (int i = 0; i < DIV_CHUNK; i++) begin
      trial   = {rem_nxt, acc_nxt[DIV_W-1]};
      acc_nxt = {acc_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        trial      = trial - {1'b0, d_r};
        acc_nxt[0] = 1'b1;
      end
      rem_nxt = trial[D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= DIV_CNT_W'(DIV_CYC);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= mag;
      rem_r <= '0;
      d_r   <= d;
      neg_r <= neg;
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign qs     = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  assign result = sat32(66'(qs));

endmodule

// File: rtl/ifs_chaos_point_generator_unit.sv
// Load item: written at the accept edge; busy stays low.
// Generate item: busy until done; out_valid is high in the first cycle with busy low again.
// One generate at a time, in ten steps; each step is set by the five row reads of the
// transform store through its single read port and by the average divider.
// The receiver cannot stall; the result stands for exactly one cycle.
// Synchronous active-low reset clears control and transform_count; the store is not cleared.
module ifs_chaos_point_generator_unit
  import ifscpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [2:0] PH_COLOR = 3'd0;
  localparam logic [2:0] PH_DLOAD = 3'd1;
  localparam logic [2:0] PH_LAST  = 3'd6;

  logic [1:0]              state_r;
  logic [2:0]              ph_r;
  logic [STEP_W-1:0]       n_r;
  logic [CNT_W-1:0]        tc_r, count_eff;
  logic [CHOICE_W-1:0]     choices_r;
  logic [ADDR_W-1:0]       base_r, raddr, waddr;
  logic [127:0]            mem [MEM_ROWS];
  logic [127:0]            rd_r;
  logic signed [31:0]      v_r [4];
  logic signed [31:0]      nv_r [3];
  logic signed [31:0]      col_r [4];
  logic signed [31:0]      col_fin [4];
  logic signed [63:0]      prod_r [4];
  logic signed [65:0]      acc_sum;
  logic signed [31:0]      row_res;
  logic                    accept, load_ok, gen_ok, div_load;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  function automatic logic [ADDR_W-1:0] pick_base(input logic [IDX_W-1:0] ch,
                                                  input logic [CNT_W-1:0] cnt);
    logic [IDX_W-1:0] idx;
    idx = ({1'b0, ch} >= cnt) ? IDX_W'(cnt - CNT_W'(1)) : ch;
    return ADDR_W'(idx) * ADDR_W'(ROWS_PER_T);
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign count_eff = (tc_r > CNT_W'(MAX_T)) ? CNT_W'(MAX_T) : tc_r;
  assign load_ok   = accept && (in_data.func == FUNC_LOAD)
                     && (in_data.element < ELEM_W'(ELEMENTS))
                     && (int'(in_data.entry) < MAX_T);
  assign gen_ok    = accept && (in_data.func == FUNC_GEN) && (count_eff != '0);
  assign div_load  = (state_r == ST_RUN) && (ph_r == PH_DLOAD);

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COUNT_ADDR[2]) ? 32'(tc_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_COUNT_ADDR[2])) begin
      tc_r <= pwdata[CNT_W-1:0];
    end
  end

  // transform store: row 0-3 matrix rows, row 4 color and size
  assign waddr = ADDR_W'(in_data.entry) * ADDR_W'(ROWS_PER_T)
               + ADDR_W'(in_data.element[ELEM_W-1:2]);
  assign raddr = (ph_r == PH_COLOR) ? base_r + ADDR_W'(ROWS_PER_T - 1)
                                    : base_r + ADDR_W'(ph_r) - ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[waddr][{in_data.element[1:0], 5'd0} +: 32] <= in_data.word;
    end
    rd_r <= mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= '0;
      n_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (gen_ok) begin
            state_r <= ST_RUN;
            ph_r    <= PH_COLOR;
            n_r     <= '0;
          end
        end
        ST_RUN: begin
          if (ph_r == PH_LAST) begin
            ph_r <= PH_COLOR;
            if (n_r == STEP_W'(ITERATIONS - 1)) begin
              state_r <= ST_FIN;
            end else begin
              n_r <= n_r + STEP_W'(1);
            end
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        ST_FIN: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // step selection: shift choices so that steps past the tenth see index 0
  always_ff @(posedge clk) begin
    if (gen_ok) begin
      choices_r <= in_data.choices >> IDX_W;
      base_r    <= pick_base(in_data.choices[IDX_W-1:0], count_eff);
    end else if ((state_r == ST_RUN) && (ph_r == PH_LAST)) begin
      choices_r <= choices_r >> IDX_W;
      base_r    <= pick_base(choices_r[IDX_W-1:0], count_eff);
    end
  end

  // matrix row times vector
  always_comb begin
    acc_sum = 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2]) + 66'(prod_r[3])
            + (66'sd1 <<< (FRAC_BITS - 1));
    row_res = sat32(acc_sum >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      prod_r[k] <= $signed(rd_r[k*32 +: 32]) * v_r[k];
    end
    if (gen_ok) begin
      v_r[0] <= in_data.origin_x;
      v_r[1] <= in_data.origin_y;
      v_r[2] <= in_data.origin_z;
      v_r[3] <= ONE_FIX;
    end else if (state_r == ST_RUN) begin
      if (ph_r == PH_LAST) begin
        v_r[0] <= nv_r[0];
        v_r[1] <= nv_r[1];
        v_r[2] <= nv_r[2];
        v_r[3] <= row_res;
      end else if (ph_r >= 3'd3) begin
        nv_r[2'(ph_r - 3'd3)] <= row_res;
      end
    end
  end

  // color and size averages
  for (genvar g = 0; g < 4; g++) begin : g_avg
    ifscpg_avgdiv u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (div_load),
      .cur    (col_r[g]),
      .add    ($signed(rd_r[g*32 +: 32])),
      .step   (n_r),
      .result (col_fin[g])
    );
  end

  always_ff @(posedge clk) begin
    if (gen_ok) begin
      col_r[0] <= START_COLOR;
      col_r[1] <= START_COLOR;
      col_r[2] <= START_COLOR;
      col_r[3] <= START_SIZE;
    end else if ((state_r == ST_RUN) && (ph_r == PH_COLOR) && (n_r != '0)) begin
      col_r <= col_fin;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      out_data_r.point_x  <= v_r[0];
      out_data_r.point_y  <= v_r[1];
      out_data_r.point_z  <= v_r[2];
      out_data_r.color_r  <= col_fin[0];
      out_data_r.color_g  <= col_fin[1];
      out_data_r.color_b  <= col_fin[2];
      out_data_r.dot_size <= col_fin[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/ifscpg_chk.sv
`include "ifs_chaos_point_generator_unit_assert.svh"
module ifscpg_chk
  import ifscpg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid
);

  // a result beat only ends a generate run
  `IFSCPG_AST_NOW(a_out_after_busy, out_valid, $past(busy) && !busy)
  // one beat per generate
  `IFSCPG_AST_NEXT(a_out_single, out_valid, !out_valid)
  // a load never holds the block
  `IFSCPG_AST_NEXT(a_load_no_busy, start && !busy && (in_data.func == FUNC_LOAD), !busy)
  // no result right after an accept
  `IFSCPG_AST_NEXT(a_no_early_out, start && !busy, !out_valid)

endmodule

bind ifs_chaos_point_generator_unit ifscpg_chk u_chk (.*);

// File: tb/ifs_chaos_point_generator_unit_tb.sv
module ifs_chaos_point_generator_unit_tb;
  import ifscpg_pkg::*;

  class point_scoreboard;
    logic signed [31:0] tstore [MAX_T*ELEMENTS];
    logic [CNT_W-1:0]   tcount;
    out_item_t          pending_points[$];
    int                 errors;

    function new();
      tcount = '0;
      errors = 0;
      foreach (tstore[i]) tstore[i] = '0;
    endfunction

    function logic signed [31:0] clip(input logic signed [67:0] v);
      if (v > 68'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -68'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // running average, rounded to nearest with ties up
    function logic signed [31:0] blend(input logic signed [31:0] cur,
                                       input logic signed [31:0] add, input int n);
      logic signed [67:0] a;
      logic signed [67:0] b;
      logic signed [67:0] q;
      a = 68'sd2 * (cur * (n + 1) + add) + (n + 2);
      b = 68'sd2 * (n + 2);
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return clip(q);
    endfunction

    function void note_input(input in_item_t it);
      logic signed [31:0] v [4];
      logic signed [31:0] nv [4];
      logic signed [31:0] col [3];
      logic signed [31:0] sz;
      logic signed [67:0] acc;
      int cnt, idx, base;
      out_item_t res;
      if (it.func == FUNC_LOAD) begin
        if (it.element < ELEMENTS) tstore[it.entry*ELEMENTS + it.element] = it.word;
        return;
      end
      cnt = (tcount > MAX_T) ? MAX_T : tcount;
      if (cnt == 0) return;
      v[0] = it.origin_x; v[1] = it.origin_y; v[2] = it.origin_z; v[3] = ONE_FIX;
      col[0] = START_COLOR; col[1] = START_COLOR; col[2] = START_COLOR;
      sz = START_SIZE;
      for (int n = 0; n < ITERATIONS; n++) begin
        idx = (n < 10) ? it.choices[3*n +: 3] : 0;
        if (idx >= cnt) idx = cnt - 1;
        base = idx * ELEMENTS;
        for (int r = 0; r < 4; r++) begin
          acc = '0;
          for (int c = 0; c < 4; c++) acc = acc + tstore[base + r*4 + c] * v[c];
          nv[r] = clip((acc + (68'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
        end
        v = nv;
        for (int k = 0; k < 3; k++) col[k] = blend(col[k], tstore[base + 16 + k], n);
        sz = blend(sz, tstore[base + 19], n);
      end
      res.point_x = v[0]; res.point_y = v[1]; res.point_z = v[2];
      res.color_r = col[0]; res.color_g = col[1]; res.color_b = col[2];
      res.dot_size = sz;
      pending_points = {pending_points, res};
    endfunction

    function void check_result(input out_item_t got);
      out_item_t exp;
      string fname [7];
      fname = '{"point_x", "point_y", "point_z", "color_r", "color_g", "color_b",
                "dot_size"};
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point %h", $time, got);
        errors++;
        return;
      end
      exp = pending_points.pop_front();
      for (int i = 0; i < 7; i++)
        if (got[224-32*(i+1) +: 32] !== exp[224-32*(i+1) +: 32]) begin
          $display("%0t: %s expected %h got %h", $time, fname[i],
                   exp[224-32*(i+1) +: 32], got[224-32*(i+1) +: 32]);
          errors++;
        end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  point_scoreboard sb = new();
  bit     no_gaps = 0;
  longint cycles = 0;

  ifs_chaos_point_generator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("ifs_chaos_point_generator_unit_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_data);

  task automatic send_beat(input in_item_t it);
    // unless no_gaps is set, idle a random number of cycles, each with a 29 percent chance
    while (!no_gaps && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  // hold off until all points are out and the block has settled
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_points.size() != 0);
    repeat (80) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_count(input logic [31:0] val);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_COUNT_ADDR; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.tcount = val[CNT_W-1:0];
  endtask

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 32'h1_0000) - 32'h8000;
    if (r < 80) return (r & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic in_item_t load_item(input int ent, input int elem, input logic [31:0] w);
    in_item_t it;
    it = '0;
    it.func = FUNC_LOAD;
    it.entry = IDX_W'(ent); it.element = ELEM_W'(elem); it.word = w;
    it.origin_x = $urandom; it.origin_y = $urandom; it.origin_z = $urandom;
    it.choices = CHOICE_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t gen_item(input logic [31:0] ox, input logic [31:0] oy,
                                        input logic [31:0] oz, input logic [29:0] ch);
    in_item_t it;
    it = '0;
    it.func = FUNC_GEN;
    it.entry = IDX_W'($urandom); it.element = ELEM_W'($urandom); it.word = $urandom;
    it.origin_x = ox; it.origin_y = oy; it.origin_z = oz; it.choices = ch;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return gen_item(pick_word(), pick_word(), pick_word(), CHOICE_W'($urandom));
    if (r < 95)
      return load_item($urandom_range(0, 7), $urandom_range(0, 19), pick_word());
    return load_item($urandom_range(0, 7), $urandom_range(20, 31), $urandom);
  endfunction

  initial begin
    logic [31:0] counts [7];
    logic [31:0] w;
    counts = '{1, 8, 15, 3, 0, 9, 5};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store: no point expected
    send_beat(gen_item(32'h7FFF_FFFF, 32'h8000_0000, 0, '1));

    // fill every transform; keep them mildly contractive, w row near identity
    for (int t = 0; t < MAX_T; t++)
      for (int e = 0; e < ELEMENTS; e++) begin
        if (e < 12) w = $urandom_range(0, 32'hC000) - 32'h6000;
        else if (e < 15) w = $urandom_range(0, 32'h400) - 32'h200;
        else if (e == 15) w = ONE_FIX;
        else w = pick_word();
        if (t == 7 && e == 19) w = 32'h7FFF_FFFF;
        if (t == 6 && e == 16) w = 32'h8000_0000;
        send_beat(load_item(t, e, w));
      end
    // out-of-range element is dropped
    send_beat(load_item(0, 31, 32'hFFFF_FFFF));

    foreach (counts[p]) begin
      write_count(counts[p]);
      if (p == 0) begin
        send_beat(gen_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
        send_beat(gen_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1));
        send_beat(gen_item(0, 0, 0, 30'h3FFF_FFFF));
      end
      if (p == 1) begin
        send_beat(gen_item(0, ONE_FIX, 32'hFFFF_0000, 30'h3FFF_FFFF));
        send_beat(gen_item(32'h1234_5678, 32'h8765_4321, 0, 30'h0AC6_88FA));
      end
      no_gaps = (p == 2);
      for (int i = 0; i < 70; i++) begin
        send_beat(random_item());
        if (p == 3 && i == 30) drain();
      end
    end
    no_gaps = 0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_points.size() == 0)
      $display("ifs_chaos_point_generator_unit_tb OK");
    else
      $display("ifs_chaos_point_generator_unit_tb NOT OK");
    $finish;
  end

endmodule
